// File: src/adpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpg_pkg
// Shared types, constants and address helpers for the attribute display
// pixel generator.
// ----------------------------------------------------------------------------
package adpg_pkg;

    localparam int DfileDepth = 6912;
    localparam int DfileAw    = $clog2(DfileDepth);

    typedef logic [DfileAw-1:0] dfile_addr_t;

    // operation codes carried in s_tuser
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_RENDER = 2'd1;
    localparam logic [1:0] OP_FRAME  = 2'd2;

    localparam logic [2:0]  WINDOW_PAGE        = 3'b010;  // 0x4000 >> 13
    localparam dfile_addr_t ATTR_BASE          = DfileAw'(13'h1800);
    localparam dfile_addr_t DFILE_LIMIT        = DfileAw'(DfileDepth);
    localparam logic [7:0]  FLASH_PERIOD_RESET = 8'd16;

    typedef struct packed {
        logic [7:0] bits;
        logic [3:0] ink;
        logic [3:0] paper;
    } cell_t;

    // interleaved bitmap layout: third, pixel row, character row, column
    function automatic dfile_addr_t bitmap_addr(input logic [7:0] line,
                                                input logic [4:0] col);
        bitmap_addr = {line[7:6], line[2:0], line[5:3], col};
    endfunction

    function automatic dfile_addr_t attr_addr(input logic [7:0] line,
                                              input logic [4:0] col);
        attr_addr = ATTR_BASE + DfileAw'({line[7:3], col});
    endfunction

endpackage

// File: src/attribute_display_pixel_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attribute_display_pixel_generator_core
// Bitmap plus attribute display file with a cell renderer and flash timing.
//
// channel   dir  tdata                                          tuser / tlast
// s_        in   [15:0] address [23:16] write_data              tuser: operation
//                [28:24] cell_column [36:29] screen_line
// m_        out  [3:0] pixel_color                              tlast: last_pixel
// cfg_      in   cfg_wdata[7:0] flash_period                    -
//
// A render transaction yields eight pixel transactions, one per clock
// while m_tready is high; the single serialiser output register takes a
// new cell only as the last pixel of the previous one is accepted. Writes
// and frame ends take effect when accepted. A render reads the display
// file when accepted; the cell is then loaded into the serialiser.
// Reset clears the control state only; the display file is not cleared.
// Output stalls back up through the read stage to s_tready.
module attribute_display_pixel_generator_core
    import adpg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [15:0] address, [23:16] write_data,
                                   // [28:24] cell_column, [36:29] screen_line
    input  logic [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] pixel_color
    output logic        m_tlast    // last_pixel
);

    logic [15:0] in_address;
    logic [7:0]  in_wdata;
    logic [4:0]  in_col;
    logic [7:0]  in_line;
    logic        s_acc, render_acc, frame_acc, wr_en;
    dfile_addr_t bmp_addr, atr_addr;

    logic        rd_valid_reg, rd_valid_next;
    logic        rd_flash_reg;
    logic        rd_bmp_ok_reg;
    logic        rd_atr_ok_reg;
    logic [7:0]  atr_raw, bmp_raw, attr, bits;

    logic [7:0]  flash_period_reg;
    logic [7:0]  frame_count_reg, frame_count_next;
    logic        flash_phase_reg, flash_phase_next;
    logic [8:0]  frame_inc, frame_limit;

    cell_t       cell_word;
    logic        cell_ready;

    assign in_address = s_tdata[15:0];
    assign in_wdata   = s_tdata[23:16];
    assign in_col     = s_tdata[28:24];
    assign in_line    = s_tdata[36:29];

    assign s_tready   = !rd_valid_reg || cell_ready;
    assign s_acc      = s_tvalid && s_tready;
    assign render_acc = s_acc && (s_tuser == OP_RENDER);
    assign frame_acc  = s_acc && (s_tuser == OP_FRAME);
    assign wr_en      = s_acc && (s_tuser == OP_WRITE)
                        && (in_address[15:13] == WINDOW_PAGE)
                        && (dfile_addr_t'(in_address[12:0]) < DFILE_LIMIT);

    assign bmp_addr = bitmap_addr(in_line, in_col);
    assign atr_addr = attr_addr(in_line, in_col);

    // at most one item per edge, so a write and a read never meet in the same cycle
    adpg_dfile u_dfile (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (dfile_addr_t'(in_address[12:0])),
        .wr_data   (in_wdata),
        .rd_en     (render_acc),
        .rd_addr_a (atr_addr),
        .rd_addr_b (bmp_addr),
        .rd_data_a (atr_raw),
        .rd_data_b (bmp_raw)
    );

    assign rd_valid_next = (rd_valid_reg && !cell_ready) || render_acc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_valid_next;
        end
    end

    // flash phase is taken when the render is accepted
    always_ff @(posedge aclk) begin
        if (render_acc) begin
            rd_flash_reg  <= flash_phase_reg;
            rd_bmp_ok_reg <= bmp_addr < DFILE_LIMIT;
            rd_atr_ok_reg <= atr_addr < DFILE_LIMIT;
        end
    end

    always_comb begin
        attr = rd_atr_ok_reg ? atr_raw : 8'd0;
        bits = rd_bmp_ok_reg ? bmp_raw : 8'd0;
        if (rd_flash_reg && attr[7]) begin
            bits = ~bits;
        end
        cell_word.bits  = bits;
        cell_word.ink   = {attr[6], attr[2:0]};
        cell_word.paper = attr[6:3];
    end

    adpg_serial u_serial (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cell_valid (rd_valid_reg),
        .cell_in    (cell_word),
        .cell_ready (cell_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // period of zero counts as 256
    assign frame_inc   = {1'b0, frame_count_reg} + 9'd1;
    assign frame_limit = {(flash_period_reg == 8'd0), flash_period_reg};

    always_comb begin
        frame_count_next = frame_count_reg;
        flash_phase_next = flash_phase_reg;
        if (frame_acc) begin
            if (frame_inc >= frame_limit) begin
                frame_count_next = 8'd0;
                flash_phase_next = !flash_phase_reg;
            end else begin
                frame_count_next = frame_inc[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flash_period_reg <= FLASH_PERIOD_RESET;
            frame_count_reg  <= 8'd0;
            flash_phase_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                flash_period_reg <= cfg_wdata;
            end
            frame_count_reg <= frame_count_next;
            flash_phase_reg <= flash_phase_next;
        end
    end

`ifndef SYNTHESIS
    a_flash_on_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(flash_phase_reg) |-> $past(frame_acc))
        else $error("flash phase changed without a frame end");

    // masked cell contents, so reads past the display file do not matter
    a_read_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg && !cell_ready |=> rd_valid_reg && $stable(cell_word)
            && $stable(rd_flash_reg))
        else $error("stalled cell data changed");

    a_render_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        render_acc |=> rd_valid_reg)
        else $error("accepted render lost before the serialiser");
`endif

endmodule

// File: src/adpg_dfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpg_dfile
// Display file store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module adpg_dfile
    import adpg_pkg::*;
(
    input  logic        aclk,
    input  logic        wr_en,
    input  dfile_addr_t wr_addr,
    input  logic [7:0]  wr_data,
    input  logic        rd_en,
    input  dfile_addr_t rd_addr_a,
    input  dfile_addr_t rd_addr_b,
    output logic [7:0]  rd_data_a,
    output logic [7:0]  rd_data_b
);

    logic [7:0] mem [DfileDepth];
    logic [7:0] rd_data_a_reg;
    logic [7:0] rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a_reg <= mem[rd_addr_a];
            rd_data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// File: src/adpg_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpg_serial
// Cell serialiser: turns one decoded cell into eight pixel transactions,
// MSB first, from an output register.
// ----------------------------------------------------------------------------
module adpg_serial
    import adpg_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cell_valid,
    input  cell_t      cell_in,
    output logic       cell_ready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [3:0] pixel_color, [7:4] zero
    output logic       m_tlast    // last_pixel
);

    logic       valid_reg, valid_next;
    logic [2:0] rem_reg, rem_next;
    logic [6:0] shift_reg, shift_next;
    logic [3:0] ink_reg, ink_next;
    logic [3:0] paper_reg, paper_next;
    logic [3:0] pix_reg, pix_next;
    logic       last_reg, last_next;
    logic       out_adv;

    always_comb begin
        out_adv    = !valid_reg || m_tready;
        cell_ready = out_adv && (rem_reg == 3'd0);
        valid_next = valid_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        ink_next   = ink_reg;
        paper_next = paper_reg;
        pix_next   = pix_reg;
        last_next  = last_reg;
        if (out_adv) begin
            if (rem_reg != 3'd0) begin
                pix_next   = shift_reg[6] ? ink_reg : paper_reg;
                shift_next = {shift_reg[5:0], 1'b0};
                rem_next   = rem_reg - 3'd1;
                last_next  = (rem_reg == 3'd1);
                valid_next = 1'b1;
            end else if (cell_valid) begin
                pix_next   = cell_in.bits[7] ? cell_in.ink : cell_in.paper;
                shift_next = cell_in.bits[6:0];
                ink_next   = cell_in.ink;
                paper_next = cell_in.paper;
                rem_next   = 3'd7;
                last_next  = 1'b0;
                valid_next = 1'b1;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rem_reg   <= 3'd0;
        end else begin
            valid_reg <= valid_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        ink_reg   <= ink_next;
        paper_reg <= paper_next;
        pix_reg   <= pix_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, pix_reg};
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    // pixels of one cell go out without gaps
    a_cell_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && m_tready && !last_reg |=> valid_reg)
        else $error("gap inside a cell");

    a_last_ends_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && last_reg |-> rem_reg == 3'd0)
        else $error("last pixel with pixels still pending");

    a_rem_has_output: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg != 3'd0 |-> valid_reg)
        else $error("pending pixels without an output transaction");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the attribute display pixel generator against a cycle-free predictor
// of the display file, the flash timing and the cell renderer. Directed cells
// at the edges of the screen and of the write window come first. Flash period
// extremes follow, and then a random stream under varying back-pressure.
// Renders only touch display bytes that have already been written.
// ----------------------------------------------------------------------------
module testbench;
    import adpg_pkg::*;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          REPORT_LIMIT  = 100;
    localparam int          ATTR_OFFSET   = 6144;
    localparam logic [15:0] WINDOW_LO     = 16'h4000;
    localparam logic [15:0] WINDOW_HI     = 16'h5B00;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;

    typedef struct {
        logic [3:0] colour;
        logic       last;
    } pixel_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;   // [15:0] address, [23:16] write_data,
                                   // [28:24] cell_column, [36:29] screen_line
    logic [1:0]  s_tuser   = 2'd0; // [1:0] operation
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // [3:0] pixel_color
    logic        m_tlast;          // last_pixel

    // predictor state
    logic [7:0] dfile_image [DfileDepth];
    bit         dfile_written [DfileDepth];
    logic [7:0] frame_count_m  = 8'd0;
    logic       flash_phase_m  = 1'b0;
    logic [7:0] flash_period_m = FLASH_PERIOD_RESET;
    pixel_t     pending_pixels [$];
    pixel_t     want_pixel;

    int tx_gap_pct    = 0;
    int rx_stall_pct  = 0;
    int mismatches    = 0;
    int items_sent    = 0;
    int renders_sent  = 0;
    int pixels_checked = 0;
    int phase_toggles = 0;
    int cycle_count   = 0;

    attribute_display_pixel_generator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels outstanding",
                     cycle_count, pending_pixels.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic int bitmap_offset(input logic [7:0] line, input logic [4:0] col);
        return int'({line[7:6], line[2:0], line[5:3], col});
    endfunction

    function automatic int attr_offset(input logic [7:0] line, input logic [4:0] col);
        return ATTR_OFFSET + int'({line[7:3], col});
    endfunction

    function automatic logic [7:0] dfile_read(input int offset);
        return (offset < DfileDepth) ? dfile_image[offset] : 8'h00;
    endfunction

    function automatic void predict_pixels(input logic [1:0] op, input logic [15:0] addr,
                                           input logic [7:0] wdata, input logic [4:0] col,
                                           input logic [7:0] line);
        int         frame_limit;
        logic [7:0] attr;
        logic [7:0] bits;
        logic [3:0] ink;
        logic [3:0] paper;
        pixel_t     px;
        case (op)
            OP_WRITE: begin
                if (addr >= WINDOW_LO && addr < WINDOW_HI) begin
                    dfile_image[addr - WINDOW_LO]   = wdata;
                    dfile_written[addr - WINDOW_LO] = 1'b1;
                end
            end
            OP_FRAME: begin
                frame_limit = (flash_period_m == 8'd0) ? 256 : int'(flash_period_m);
                if (int'(frame_count_m) + 1 >= frame_limit) begin
                    frame_count_m = 8'd0;
                    flash_phase_m = ~flash_phase_m;
                    phase_toggles++;
                end else begin
                    frame_count_m = frame_count_m + 8'd1;
                end
            end
            OP_RENDER: begin
                attr  = dfile_read(attr_offset(line, col));
                bits  = dfile_read(bitmap_offset(line, col));
                ink   = {attr[6], attr[2:0]};
                paper = attr[6:3];
                if (flash_phase_m && attr[7])
                    bits = ~bits;
                for (int k = 0; k < 8; k++) begin
                    px.colour = bits[7-k] ? ink : paper;
                    px.last   = (k == 7);
                    pending_pixels.push_back(px);
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        // keep the log bounded on a badly broken build; every one still counts
        if (mismatches < REPORT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("pixel %0h with nothing expected", m_tdata));
            end else begin
                want_pixel = pending_pixels.pop_front();
                if (m_tdata !== {4'b0000, want_pixel.colour})
                    report_mismatch($sformatf("pixel %0d colour %0h, expected %0h",
                                              pixels_checked, m_tdata, want_pixel.colour));
                if (m_tlast !== want_pixel.last)
                    report_mismatch($sformatf("pixel %0d last %b, expected %b",
                                              pixels_checked, m_tlast, want_pixel.last));
                pixels_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0] op, input logic [15:0] addr,
                             input logic [7:0] wdata, input logic [4:0] col,
                             input logic [7:0] line);
        while ($urandom_range(99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, line, col, wdata, addr};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_pixels(op, addr, wdata, col, line);
        items_sent++;
        if (op == OP_RENDER)
            renders_sent++;
    endtask

    task automatic write_byte(input int offset, input logic [7:0] value);
        send_item(OP_WRITE, WINDOW_LO + 16'(offset), value,
                  5'($urandom_range(31)), 8'($urandom_range(255)));
    endtask

    task automatic end_frames(input int count);
        repeat (count)
            send_item(OP_FRAME, 16'($urandom), 8'($urandom),
                      5'($urandom_range(31)), 8'($urandom_range(255)));
    endtask

    // fills any display byte the cell would read that has not been loaded yet
    task automatic render_cell(input logic [4:0] col, input logic [7:0] line);
        int offs [2];
        offs[0] = bitmap_offset(line, col);
        offs[1] = attr_offset(line, col);
        foreach (offs[i])
            if (offs[i] < DfileDepth && !dfile_written[offs[i]])
                write_byte(offs[i], 8'($urandom));
        send_item(OP_RENDER, 16'($urandom), 8'($urandom), col, line);
    endtask

    // drains the pipeline; frame ends and writes leave no pixel behind them
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_pixels.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_flash_period(input logic [7:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        flash_period_m = value;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed_cells();
        tx_gap_pct   = 20;
        rx_stall_pct = 68;
        // window edges: 0x4000 is the first bitmap byte, 0x5AFF the last attribute
        write_byte(bitmap_offset(8'd0, 5'd0), 8'hA5);
        write_byte(attr_offset(8'd0, 5'd0), 8'h47);
        render_cell(5'd0, 8'd0);
        write_byte(bitmap_offset(8'd191, 5'd31), 8'h00);
        write_byte(DfileDepth - 1, 8'hFF);
        render_cell(5'd31, 8'd191);
        write_byte(bitmap_offset(8'd64, 5'd5), 8'hFF);
        write_byte(attr_offset(8'd64, 5'd5), 8'h38);
        render_cell(5'd5, 8'd64);
        // writes just outside the window and an unused code must change nothing
        send_item(OP_WRITE, WINDOW_LO - 16'd1, 8'h00, 5'd31, 8'd255);
        send_item(OP_WRITE, WINDOW_HI, 8'hFF, 5'd0, 8'd0);
        send_item(OP_WRITE, 16'hFFFF, 8'h00, 5'd0, 8'd0);
        send_item(OP_WRITE, 16'h0000, 8'hFF, 5'd31, 8'd255);
        send_item(OP_UNUSED, 16'hFFFF, 8'hFF, 5'd31, 8'd255);
        render_cell(5'd0, 8'd0);
        // lines past the display area
        render_cell(5'd31, 8'd255);
        render_cell(5'd0, 8'd192);
    endtask

    task automatic test_flash_timing();
        logic [4:0] col;
        logic [7:0] line;
        col  = 5'd7;
        line = 8'd100;
        write_byte(attr_offset(line, col), 8'hC6);
        write_byte(bitmap_offset(line, col), 8'hF0);
        set_flash_period(8'd1);
        render_cell(col, line);
        end_frames(1);
        render_cell(col, line);
        end_frames(1);
        render_cell(col, line);
        // zero period behaves as 256 frames
        set_flash_period(8'd0);
        end_frames(255);
        render_cell(col, line);
        end_frames(1);
        render_cell(col, line);
        // period dropped below the running count
        set_flash_period(8'd200);
        end_frames(10);
        set_flash_period(8'd3);
        end_frames(1);
        render_cell(col, line);
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) begin
            render_cell(5'($urandom_range(31)),
                        ($urandom_range(9) == 0) ? 8'($urandom_range(255, 192))
                                                 : 8'($urandom_range(191)));
        end else if (pick < 70) begin
            write_byte($urandom_range(DfileDepth - 1), 8'($urandom));
        end else if (pick < 80) begin
            send_item(OP_WRITE, 16'($urandom), 8'($urandom),
                      5'($urandom_range(31)), 8'($urandom_range(255)));
        end else if (pick < 96) begin
            end_frames(1);
        end else begin
            send_item(OP_UNUSED, 16'($urandom), 8'($urandom),
                      5'($urandom_range(31)), 8'($urandom_range(255)));
        end
    endtask

    task automatic test_random_stream();
        int gap_pct   [3] = '{20, 68, 0};
        int stall_pct [3] = '{68, 20, 0};
        for (int p = 0; p < 3; p++) begin
            set_flash_period(8'($urandom_range(4, 1)));
            tx_gap_pct   = gap_pct[p];
            rx_stall_pct = stall_pct[p];
            repeat (16)
                random_item();
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cells();
        test_flash_timing();
        test_random_stream();
        wait_idle();
        repeat (16) @(posedge aclk);
        $display("%0d transactions in, %0d renders, %0d pixels compared",
                 items_sent, renders_sent, pixels_checked);
        $display("%0d flash phase toggles predicted, %0d mismatches",
                 phase_toggles, mismatches);
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
src/adpg_pkg.sv
src/adpg_dfile.sv
src/adpg_serial.sv
src/attribute_display_pixel_generator_core.sv
tb/testbench.sv
